// ===== rtl/lztd_pkg.sv =====
// lztd_pkg: shared types and constants of the LZ77 token decoder.
// No dependencies; used by the interfaces and lz77_token_decoder.
package lztd_pkg;

    // Item kinds on the token channel
    localparam logic OP_FLAGS = 1'b0;
    localparam logic OP_TOKEN = 1'b1;

    // Result error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_FLAGS = 2'd1;
    localparam logic [1:0] ERR_BAD_DIST = 2'd2;
    localparam logic [1:0] ERR_PAST_END = 2'd3;

    // Format constants
    localparam logic [7:0] FLAG_TOP  = 8'h80;
    localparam logic [8:0] MIN_LEN   = 9'd3;
    localparam logic [3:0] LANES     = 4'd8;
    localparam logic [3:0] FLAG_BITS = 4'd8;

    // Payload types
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_dist;
    typedef logic [63:0] t_data;
    typedef logic [3:0]  t_count;
    typedef logic [1:0]  t_err;

    // Sequencer states (one-hot)
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_WRITE = 4'b0100,
        S_PUSH  = 4'b1000
    } t_state;

endpackage

// ===== rtl/lztd_tok_if.sv =====
// lztd_tok_if: valid/ready channel that carries flag bytes and data tokens.
// Depends on lztd_pkg for the payload types.
interface lztd_tok_if;
    import lztd_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    t_byte flag_byte;
    t_byte code_byte;
    t_dist distance;

    modport source (output valid, op, flag_byte, code_byte, distance, input ready);
    modport sink   (input valid, op, flag_byte, code_byte, distance, output ready);
endinterface

// ===== rtl/lztd_res_if.sv =====
// lztd_res_if: valid/ready channel that carries decoded byte groups.
// Depends on lztd_pkg for the payload types.
interface lztd_res_if;
    import lztd_pkg::*;

    logic   valid;
    logic   ready;
    t_data  data;
    t_count byte_count;
    logic   last;
    t_err   error;
    logic   finished;

    modport source (output valid, data, byte_count, last, error, finished, input ready);
    modport sink   (input valid, data, byte_count, last, error, finished, output ready);
endinterface

// ===== rtl/lztd_history.sv =====
// lztd_history: history window RAM, one write port and one registered read port.
// No package dependency; contents are undefined until written.
module lztd_history #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/lz77_token_decoder.sv =====
// lz77_token_decoder: LZ77 decoder top level, flag/token sequencer and result register.
// Depends on lztd_pkg, lztd_tok_if, lztd_res_if and lztd_history.
// A flag byte is loaded in S_IDLE; a literal or error token goes from S_IDLE to S_PUSH,
// which registers the result and frees the input. A match copies each byte through
// S_READ (history read) then S_WRITE (write-back), and passes S_PUSH once per group
// of 8 bytes or at its end. One token is in work at a time; a held result register stalls
// the push step until it drains. Reset clears the write pointer, flags, byte count and
// total_bytes; history is not cleared.
module lz77_token_decoder #(
    parameter int WINDOW = 32768
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [31:0]               i_cfg_wr_data,
    lztd_tok_if.sink                  i_tok,
    lztd_res_if.source                o_res
);
    import lztd_pkg::*;

    localparam int PTR_W = $clog2(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [PTR_W:0]   WIN_E    = (PTR_W + 1)'(WINDOW);
    localparam logic [16:0]      WIN_D    = 17'(WINDOW);

    // Control and datapath registers
    t_state           r_state, n_state;
    logic [31:0]      r_total, n_total;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [7:0]       r_flag_shift, n_flag_shift;
    logic [3:0]       r_flags_left, n_flags_left;
    logic [32:0]      r_produced, n_produced;
    logic [8:0]       r_remaining, n_remaining;
    t_data            r_acc, n_acc;
    t_count           r_lane, n_lane;
    logic             r_last, n_last;
    t_err             r_err, n_err;

    // Output register
    logic             r_out_valid, n_out_valid;
    t_data            r_out_data, n_out_data;
    t_count           r_out_count, n_out_count;
    logic             r_out_last, n_out_last;
    t_err             r_out_err, n_out_err;
    logic             r_out_fin, n_out_fin;

    // History port signals
    logic             mem_wr_en;
    logic [7:0]       mem_wr_data;
    logic             mem_rd_en;
    logic [7:0]       mem_rd_data;

    logic             tok_accept;
    logic             past_end;
    logic             bad_dist;
    logic [PTR_W:0]   wp_e;
    logic [PTR_W:0]   dist_e;
    logic [PTR_W:0]   src_e;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rd_inc;
    logic             out_free;

    lztd_history #(
        .DEPTH  (WINDOW),
        .ADDR_W (PTR_W)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (mem_rd_data)
    );

    assign i_tok.ready = (r_state == S_IDLE);
    assign tok_accept  = i_tok.valid && i_tok.ready;

    // Window arithmetic: pointer wrap, copy source, distance check
    assign wp_inc   = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rd_inc   = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
    assign wp_e     = {1'b0, r_wp};
    assign dist_e   = (PTR_W + 1)'(i_tok.distance);
    assign src_e    = (wp_e >= dist_e) ? (wp_e - dist_e) : (wp_e + WIN_E - dist_e);
    assign past_end = r_produced >= {1'b0, r_total};
    assign bad_dist = (i_tok.distance == '0)
                   || ({17'd0, i_tok.distance} > r_produced)
                   || ({1'b0, i_tok.distance} > WIN_D);

    assign out_free = !r_out_valid || o_res.ready;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_wp         = r_wp;
        n_rd_ptr     = r_rd_ptr;
        n_flag_shift = r_flag_shift;
        n_flags_left = r_flags_left;
        n_produced   = r_produced;
        n_remaining  = r_remaining;
        n_acc        = r_acc;
        n_lane       = r_lane;
        n_last       = r_last;
        n_err        = r_err;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        n_out_fin    = r_out_fin;
        mem_wr_en    = 1'b0;
        mem_wr_data  = mem_rd_data;
        mem_rd_en    = 1'b0;

        if (i_cfg_wr_en) begin
            n_total = i_cfg_wr_data;
        end

        // Result handed off downstream
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (tok_accept) begin
                    n_acc  = '0;
                    n_lane = '0;
                    n_last = 1'b1;
                    n_err  = ERR_NONE;
                    if (i_tok.op == OP_FLAGS) begin
                        n_flag_shift = i_tok.flag_byte;
                        n_flags_left = FLAG_BITS;
                    end else if (past_end) begin
                        n_err   = ERR_PAST_END;
                        n_state = S_PUSH;
                    end else if (r_flags_left == '0) begin
                        n_err   = ERR_NO_FLAGS;
                        n_state = S_PUSH;
                    end else begin
                        n_flag_shift = {r_flag_shift[6:0], 1'b0};
                        n_flags_left = r_flags_left - 1'b1;
                        n_state      = S_PUSH;
                        if ((r_flag_shift & FLAG_TOP) == '0) begin
                            // Literal: write it to the history at once and emit it from S_PUSH
                            mem_wr_en   = 1'b1;
                            mem_wr_data = i_tok.code_byte;
                            n_wp        = wp_inc;
                            n_produced  = r_produced + 1'b1;
                            n_acc       = {56'd0, i_tok.code_byte};
                            n_lane      = 4'd1;
                        end else if (bad_dist) begin
                            n_err = ERR_BAD_DIST;
                        end else begin
                            n_rd_ptr    = PTR_W'(src_e);
                            n_remaining = {1'b0, i_tok.code_byte} + MIN_LEN;
                            n_last      = 1'b0;
                            n_state     = S_READ;
                        end
                    end
                end
            end

            S_READ: begin
                mem_rd_en = 1'b1;
                n_state   = S_WRITE;
            end

            // Copy one byte back into the window and into the current group
            S_WRITE: begin
                mem_wr_en                  = 1'b1;
                mem_wr_data                = mem_rd_data;
                n_wp                       = wp_inc;
                n_rd_ptr                   = rd_inc;
                n_produced                 = r_produced + 1'b1;
                n_acc[r_lane[2:0] * 8 +: 8] = mem_rd_data;
                n_lane                     = r_lane + 1'b1;
                n_remaining                = r_remaining - 1'b1;
                if (r_remaining == 9'd1) begin
                    n_last  = 1'b1;
                    n_state = S_PUSH;
                end else if (r_lane + 1'b1 == LANES) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_READ;
                end
            end

            S_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_out_count = r_lane;
                    n_out_last  = r_last;
                    n_out_err   = r_err;
                    n_out_fin   = past_end;
                    n_acc       = '0;
                    n_lane      = '0;
                    n_state     = r_last ? S_IDLE : S_READ;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_wp         <= '0;
            r_flag_shift <= '0;
            r_flags_left <= '0;
            r_produced   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_wp         <= n_wp;
            r_flag_shift <= n_flag_shift;
            r_flags_left <= n_flags_left;
            r_produced   <= n_produced;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_ptr    <= n_rd_ptr;
        r_remaining <= n_remaining;
        r_acc       <= n_acc;
        r_lane      <= n_lane;
        r_last      <= n_last;
        r_err       <= n_err;
        r_out_data  <= n_out_data;
        r_out_count <= n_out_count;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
        r_out_fin   <= n_out_fin;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data       = r_out_data;
    assign o_res.byte_count = r_out_count;
    assign o_res.last       = r_out_last;
    assign o_res.error      = r_out_err;
    assign o_res.finished   = r_out_fin;

endmodule
